### rtl/oversampled_async_byte_deframer_top_assert.svh
`ifndef OVERSAMPLED_ASYNC_BYTE_DEFRAMER_TOP_ASSERT_SVH
`define OVERSAMPLED_ASYNC_BYTE_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OBD_CHECK(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("obd check failed");

// next-cycle implication, checked outside reset
`define OBD_CHECK_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("obd next-cycle check failed");

`endif

### rtl/obd_pkg.sv
package obd_pkg;

  localparam int MAX_OUT = 64;
  localparam logic [6:0] LIMIT_RESET = 7'd64;
  localparam logic [3:0] STOP_LAST = 4'd10;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last_in_packet;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic [6:0] byte_count;
    logic       limit_reached;
  } dec_item_t;

  typedef struct packed {
    logic       in_frame;
    logic [3:0] group_index;
    logic [7:0] data_shift;
    logic [6:0] decoded_count;
  } frame_state_t;

  typedef struct packed {
    frame_state_t st;
    logic         emit;
    dec_item_t    item;
  } group_result_t;

  typedef struct packed {
    logic      emit;
    dec_item_t item;
  } dec_step_t;

  // two or more ones out of four, so a tie gives 1
  function automatic logic vote(input logic [3:0] nib);
    logic [2:0] ones;
    ones = {2'b00, nib[0]} + {2'b00, nib[1]} + {2'b00, nib[2]} + {2'b00, nib[3]};
    return (ones >= 3'd2);
  endfunction

  function automatic group_result_t group_step(input frame_state_t st, input logic line_bit,
                                               input logic [6:0] lim);
    group_result_t r;
    logic [6:0]    cnt;
    r      = '0;
    r.st   = st;
    cnt    = st.decoded_count + 7'd1;
    if (st.decoded_count >= lim) begin
      r.emit = 1'b0;
    end else if (!st.in_frame) begin
      if (!line_bit) begin
        r.st.in_frame    = 1'b1;
        r.st.group_index = 4'd0;
        r.st.data_shift  = 8'd0;
      end
    end else begin
      if (!st.group_index[3]) begin
        r.st.data_shift[st.group_index[2:0]] = st.data_shift[st.group_index[2:0]] | line_bit;
      end
      if (st.group_index >= STOP_LAST) begin
        r.emit               = 1'b1;
        r.item.decoded_byte  = r.st.data_shift;
        r.item.byte_count    = cnt;
        r.item.limit_reached = (cnt == lim);
        r.st.in_frame        = 1'b0;
        r.st.group_index     = 4'd0;
        r.st.data_shift      = 8'd0;
        r.st.decoded_count   = cnt;
      end else begin
        r.st.group_index = st.group_index + 4'd1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/obd_in_reg.sv
module obd_in_reg
  import obd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      raw_valid,
  output logic      raw_stall,
  input  raw_item_t raw_item,
  input  logic      advance,
  output logic      hold_valid,
  output raw_item_t hold_item
);

  // full holding register only waits when the result side cannot move
  assign raw_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!raw_stall) begin
      hold_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && !raw_stall) begin
      hold_item <= raw_item;
    end
  end

endmodule

### rtl/obd_decode.sv
module obd_decode
  import obd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       hold_valid,
  input  raw_item_t  hold_item,
  input  logic       advance,
  output dec_step_t  step
);

  logic [6:0]    decode_limit;
  logic [6:0]    lim;
  frame_state_t  state;
  group_result_t first;
  group_result_t second;

  // clamp to 1..MAX_OUT
  always_comb begin
    if (decode_limit == 7'd0) begin
      lim = 7'd1;
    end else if ({1'b0, decode_limit} > 8'(MAX_OUT)) begin
      lim = 7'(MAX_OUT);
    end else begin
      lim = decode_limit;
    end
  end

  // first group is the high nibble
  always_comb begin
    first  = group_step(state, vote(hold_item.raw_byte[7:4]), lim);
    second = group_step(first.st, vote(hold_item.raw_byte[3:0]), lim);
  end

  // a frame spans twelve groups, so at most one of the two emits
  assign step.emit = first.emit || second.emit;
  assign step.item = first.emit ? first.item : second.item;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      decode_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (hold_valid && advance) begin
      if (hold_item.last_in_packet) begin
        state <= '0;
      end else begin
        state <= second.st;
      end
    end
  end

endmodule

### rtl/obd_out_reg.sv
module obd_out_reg
  import obd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      hold_valid,
  input  dec_step_t step,
  output logic      advance,
  output logic      dec_valid,
  input  logic      dec_stall,
  output dec_item_t dec_item
);

  assign advance = !dec_valid || !dec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (advance) begin
      dec_valid <= hold_valid && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid && step.emit) begin
      dec_item <= step.item;
    end
  end

endmodule

### rtl/oversampled_async_byte_deframer_top.sv
// 4x oversampled async byte deframer
// raw channel: raw_valid/raw_stall/raw_item carries one byte of eight line
//   samples (first sample in bit 7) and a last_in_packet flag
// dec channel: dec_valid/dec_stall/dec_item carries a recovered byte, the
//   running byte count of the packet and a limit_reached flag
// cfg_we/cfg_data write decode_limit (0 acts as 1, values above 64 act as 64)
// each raw byte gives two majority-voted line bits; a start bit, 8 data bits
//   and 3 stop bits make a frame, so a byte comes out at most once per input
// throughput: one raw byte per cycle while no stalled result holds it back, set by
//   the combinational two-group update of the frame state between holding and result register
// the raw byte that completes a result passes the holding register, then the result register
// once the limit is hit nothing more comes out until last_in_packet clears
//   the frame state and byte count
// reset clears frame state and both valid flags and sets decode_limit to 64
// while dec_stall holds a waiting result the holding register still takes
//   one more raw byte, then raw_stall rises
`include "oversampled_async_byte_deframer_top_assert.svh"

module oversampled_async_byte_deframer_top
  import obd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       raw_valid,
  output logic       raw_stall,
  input  raw_item_t  raw_item,
  output logic       dec_valid,
  input  logic       dec_stall,
  output dec_item_t  dec_item
);

  logic      advance;
  logic      hold_valid;
  raw_item_t hold_item;
  dec_step_t step;

  obd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .raw_valid  (raw_valid),
    .raw_stall  (raw_stall),
    .raw_item   (raw_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  obd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .advance    (advance),
    .step       (step)
  );

  obd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .step       (step),
    .advance    (advance),
    .dec_valid  (dec_valid),
    .dec_stall  (dec_stall),
    .dec_item   (dec_item)
  );

  // back-pressure only comes from a stalled, full result register
  `OBD_CHECK(a_stall_from_output, raw_stall, dec_valid && dec_stall)
  `OBD_CHECK(a_count_nonzero, dec_valid, dec_item.byte_count != 7'd0)
  `OBD_CHECK(a_limit_bound, dec_valid && dec_item.limit_reached, dec_item.byte_count <= 7'(MAX_OUT))
  // a held item with a free result side always moves on
  `OBD_CHECK_NEXT(a_hold_drains, hold_valid && advance && !raw_valid, !hold_valid)

endmodule

### tb/tb_oversampled_async_byte_deframer_top.sv
module tb_oversampled_async_byte_deframer_top
  import obd_pkg::*;
();

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 155;
  localparam logic [6:0] PHASE_LIMITS [5] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd63};
  // start bit, seven data ones via 2-2 ties, then ones for data bit 7 and the stops
  localparam logic [7:0] TIE_FRAME [6] = '{8'h13, 8'hC5, 8'hA9, 8'h63, 8'hFF, 8'h7B};

  // tracks the deframer state and the decoded bytes still to come out
  class decoded_byte_tracker;
    logic [6:0] limit_reg;
    logic       in_frame;
    logic [3:0] grp_idx;
    logic [7:0] shift;
    logic [6:0] count;
    dec_item_t  awaited_bytes[$];
    int         bad_results;

    function new();
      limit_reg   = LIMIT_RESET;
      bad_results = 0;
      clear_frame();
      count = '0;
    endfunction

    function void clear_frame();
      in_frame = 1'b0;
      grp_idx  = '0;
      shift    = '0;
    endfunction

    function void set_limit(logic [6:0] v);
      limit_reg = v;
    endfunction

    function void take_raw(raw_item_t it);
      int unsigned lim;
      logic [3:0]  nib;
      logic        line_bit;
      dec_item_t   want;
      lim = limit_reg;
      if (lim < 1) lim = 1;
      if (lim > MAX_OUT) lim = MAX_OUT;
      for (int g = 0; g < 2; g++) begin
        if (count >= lim) break;
        nib = (g == 0) ? it.raw_byte[7:4] : it.raw_byte[3:0];
        line_bit = ($countones(nib) >= 2);
        if (!in_frame) begin
          // hunting: a low group is the start bit
          if (!line_bit) begin
            in_frame = 1'b1;
            grp_idx  = '0;
            shift    = '0;
          end
          continue;
        end
        if (grp_idx < 8 && line_bit) shift[grp_idx[2:0]] = 1'b1;
        if (grp_idx >= STOP_LAST) begin
          count = count + 7'd1;
          want.decoded_byte  = shift;
          want.byte_count    = count;
          want.limit_reached = (count == lim);
          awaited_bytes.push_back(want);
          clear_frame();
        end else begin
          grp_idx = grp_idx + 4'd1;
        end
      end
      if (it.last_in_packet) begin
        clear_frame();
        count = '0;
      end
    endfunction

    function void match_decoded(dec_item_t got);
      dec_item_t want;
      if (awaited_bytes.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected decoded byte %h count %0d limit %b",
                   got.decoded_byte, got.byte_count, got.limit_reached);
        return;
      end
      want = awaited_bytes.pop_front();
      if (got.decoded_byte !== want.decoded_byte || got.byte_count !== want.byte_count ||
          got.limit_reached !== want.limit_reached) begin
        bad_results++;
        if (bad_results <= 10)
          $display("mismatch: expected byte %h count %0d limit %b, got byte %h count %0d limit %b",
                   want.decoded_byte, want.byte_count, want.limit_reached,
                   got.decoded_byte, got.byte_count, got.limit_reached);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;
  logic       raw_valid;
  logic       raw_stall;
  raw_item_t  raw_item;
  logic       dec_valid;
  logic       dec_stall;
  dec_item_t  dec_item;

  logic rx_rand_stall;
  logic rx_hold;
  logic hold_go = 1'b0;
  int   tx_gap_max = 0;
  int   rx_stall_max = 0;

  logic      line_q[$];
  raw_item_t stim_q[$];

  decoded_byte_tracker tracker = new();

  assign dec_stall = rx_rand_stall | rx_hold;

  oversampled_async_byte_deframer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_item  (raw_item),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_item  (dec_item)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // random sample nibble whose majority vote gives the wanted line bit
  function automatic logic [3:0] nib_for(logic b);
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    while (($countones(n) >= 2) != b) n = 4'($urandom_range(0, 15));
    return n;
  endfunction

  function automatic void add_idle(int n);
    repeat (n) line_q.push_back(1'b1);
  endfunction

  // start, eight data bits lsb first, three stops; only the first ngroups are kept
  function automatic void add_frame(logic [7:0] data, bit junk_stops, int ngroups);
    logic grp[12];
    grp[0] = 1'b0;
    for (int i = 0; i < 8; i++) grp[i + 1] = data[i];
    for (int i = 9; i < 12; i++) grp[i] = junk_stops ? 1'($urandom) : 1'b1;
    for (int i = 0; i < ngroups; i++) line_q.push_back(grp[i]);
  endfunction

  function automatic void pack_groups(bit last);
    logic hi, lo;
    while (line_q.size() > 0) begin
      hi = line_q.pop_front();
      lo = (line_q.size() > 0) ? line_q.pop_front() : 1'b1;
      stim_q.push_back('{raw_byte: {nib_for(hi), nib_for(lo)}, last_in_packet: 1'b0});
    end
    if (last && stim_q.size() > 0) stim_q[stim_q.size() - 1].last_in_packet = 1'b1;
  endfunction

  task automatic build_random(int n);
    int kind;
    int k;
    while (stim_q.size() < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          stim_q.push_back('{raw_byte: 8'($urandom), last_in_packet: ($urandom_range(0, 7) == 0)});
      end else if (kind == 1) begin
        // broken frame cut off by the end of the packet
        add_idle($urandom_range(0, 3));
        add_frame(8'($urandom), 1'b1, $urandom_range(1, 11));
        pack_groups(1'b1);
      end else begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          add_idle($urandom_range(0, 3));
          add_frame(8'($urandom), ($urandom_range(0, 4) == 0), 12);
        end
        pack_groups($urandom_range(0, 3) != 0);
      end
    end
  endtask

  task automatic send_all();
    raw_item_t it;
    int        gap;
    while (stim_q.size() > 0) begin
      it  = stim_q.pop_front();
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        raw_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      raw_valid <= 1'b1;
      raw_item  <= it;
      @(posedge clk);
      while (raw_stall !== 1'b0) @(posedge clk);
      tracker.take_raw(it);
    end
    raw_valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.awaited_bytes.size() != 0) @(posedge clk);
    // inputs that produce nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limit(v);
  endtask

  // receiver: random stall before each transfer
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, rx_stall_max);
      if (n > 0) begin
        rx_rand_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rx_rand_stall <= 1'b0;
      @(posedge clk);
      while (!(dec_valid === 1'b1 && dec_stall === 1'b0)) @(posedge clk);
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    rx_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && dec_valid === 1'b1 && dec_stall === 1'b0) tracker.match_decoded(dec_item);
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [6:0] lim;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    raw_valid <= 1'b0;
    raw_item  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tie votes, an all-zero data byte, a frame dropped by end of packet
    foreach (TIE_FRAME[i]) stim_q.push_back('{raw_byte: TIE_FRAME[i], last_in_packet: (i == 5)});
    add_frame(8'h00, 1'b0, 12);
    pack_groups(1'b1);
    add_idle(1);
    add_frame(8'h5A, 1'b0, 6);
    pack_groups(1'b1);
    send_all();
    drain();

    // limit 0 acts as 1; the byte ends on a first group and the next start is ignored
    write_limit(7'd0);
    add_idle(1);
    add_frame(8'h81, 1'b0, 12);
    add_frame(8'h3C, 1'b0, 2);
    pack_groups(1'b0);
    send_all();
    drain();

    for (int p = 0; p < 8; p++) begin
      lim = (p < 5) ? PHASE_LIMITS[p] : 7'($urandom_range(0, 127));
      write_limit(lim);
      tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 12;
      rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      if (p == 0) begin
        tx_gap_max = 0;
        hold_go    = 1'b1;
      end
      build_random(PHASE_ITEMS);
      send_all();
      drain();
    end

    if (tracker.bad_results == 0 && tracker.awaited_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
